// ===== sv/fhp_pkg.sv =====
// Shared constants, types and the color palette of the fire heat propagation unit.
package fhp_pkg;

   localparam int FHP_GRID_SIZE        = 16;
   localparam int FHP_FIRST_SOURCE_ROW = 4;
   localparam int FHP_MAX_EMIT         = 16;

   localparam logic [5:0]  HEAT_MAX    = 6'd36;
   localparam logic [15:0] LIMIT_RESET = 16'd250;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef struct packed {
      logic start;
      logic first_col;
      logic last_col;
   } fhp_frame_cmd_type;

   function automatic logic [23:0] fhp_palette(input logic [5:0] heat);
      logic [23:0] rgb;
      case (heat)
         6'd0:    rgb = 24'h070707;
         6'd1:    rgb = 24'h1F0707;
         6'd2:    rgb = 24'h2F0F07;
         6'd3:    rgb = 24'h470F07;
         6'd4:    rgb = 24'h571707;
         6'd5:    rgb = 24'h671F07;
         6'd6:    rgb = 24'h771F07;
         6'd7:    rgb = 24'h8F2707;
         6'd8:    rgb = 24'h9F2F07;
         6'd9:    rgb = 24'hAF3F07;
         6'd10:   rgb = 24'hBF4707;
         6'd11:   rgb = 24'hC74707;
         6'd12:   rgb = 24'hDF4F07;
         6'd13:   rgb = 24'hDF5707;
         6'd14:   rgb = 24'hDF5707;
         6'd15:   rgb = 24'hD75F07;
         6'd16:   rgb = 24'hD75F07;
         6'd17:   rgb = 24'hD7670F;
         6'd18:   rgb = 24'hCF6F0F;
         6'd19:   rgb = 24'hCF770F;
         6'd20:   rgb = 24'hCF7F0F;
         6'd21:   rgb = 24'hCF8717;
         6'd22:   rgb = 24'hC78717;
         6'd23:   rgb = 24'hC78F17;
         6'd24:   rgb = 24'hC7971F;
         6'd25:   rgb = 24'hBF9F1F;
         6'd26:   rgb = 24'hBF9F1F;
         6'd27:   rgb = 24'hBFA727;
         6'd28:   rgb = 24'hBFA727;
         6'd29:   rgb = 24'hBFAF2F;
         6'd30:   rgb = 24'hB7AF2F;
         6'd31:   rgb = 24'hB7B72F;
         6'd32:   rgb = 24'hB7B737;
         6'd33:   rgb = 24'hCFCF6F;
         6'd34:   rgb = 24'hDFDF9F;
         6'd35:   rgb = 24'hEFEFC7;
         default: rgb = 24'hFFFFFF;
      endcase
      return rgb;
   endfunction

endpackage

// ===== sv/fire_heat_propagation_unit.sv =====
// Fire heat propagation unit: column-serial heat store update and palette pixel output.
//
// An update item reads source rows FIRST_SOURCE_ROW to GRID_SIZE-1 of its
// column through the one read and one write port of the heat store, one source
// row a cycle, and writes each back one row above, or two above when it decays;
// it then emits up to 16 pixels, each by a store read and then a palette lookup
// into the output register. After reset, and for each store reset item, the unit
// clears all 2^(2 * ceil(log2 GRID_SIZE)) store entries (256 at the default
// size) with req_stall high. Update items naming a column outside the grid are
// taken while the unit stays idle and give no pixels.
module fire_heat_propagation_unit #(
   parameter int GRID_SIZE        = fhp_pkg::FHP_GRID_SIZE,
   parameter int FIRST_SOURCE_ROW = fhp_pkg::FHP_FIRST_SOURCE_ROW
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [3:0]  req_column,
   input  logic [15:0] req_decay_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_row,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last,
   output logic        rsp_frame_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_frame_limit
);
   import fhp_pkg::*;

   localparam int RW       = $clog2(GRID_SIZE);
   localparam int CW       = $clog2(GRID_SIZE + 1);
   localparam int AW       = 2 * RW;
   localparam int DEPTH    = 1 << AW;
   localparam int NUM_EMIT = (GRID_SIZE < FHP_MAX_EMIT) ? GRID_SIZE : FHP_MAX_EMIT;

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_UPD     = 5'b00100,
      ST_EMIT_RD = 5'b01000,
      ST_EMIT_LD = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [CW-1:0]     row_ff, row_in;
   logic              pend_ff, pend_in;
   logic [RW-1:0]     col_ff, col_in;
   logic [15:0]       bits_ff, bits_in;
   logic              done_ff, done_in;
   logic [15:0]       limit_ff, limit_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [3:0]        rsp_row_ff, rsp_row_in;
   logic [23:0]       rsp_rgb_ff, rsp_rgb_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;

   logic [5:0]        mem [DEPTH];
   logic [5:0]        rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [5:0]        wr_data;

   logic              accept;
   logic              col_ok;
   logic              issue;
   logic [CW-1:0]     src_row;
   logic [15:0]       decay_shift;
   logic              decay;
   logic [CW-1:0]     dst_row;
   logic              out_free;
   logic              emit_last;
   logic              frame_done;
   fhp_frame_cmd_type frame_cmd;

   assign accept      = req_valid && !req_stall;
   assign col_ok      = (32'(req_column) < 32'(GRID_SIZE));
   assign issue       = (row_ff != CW'(GRID_SIZE));
   assign src_row     = row_ff - CW'(1);
   assign decay_shift = bits_ff >> src_row;
   assign decay       = decay_shift[0] && (rd_data_ff != 6'd0);
   assign dst_row     = src_row - CW'(1) - CW'(decay);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign emit_last   = (row_ff == CW'(NUM_EMIT - 1));

   assign frame_cmd.start     = accept && (req_op == OP_UPDATE) && col_ok;
   assign frame_cmd.first_col = (req_column == 4'd0);
   assign frame_cmd.last_col  = (32'(req_column) == 32'(GRID_SIZE - 1));

   fhp_frame_ctr u_frame_ctr (
      .clock       (clock),
      .reset       (reset),
      .cmd         (frame_cmd),
      .frame_limit (limit_ff),
      .done        (frame_done)
   );

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      row_in      = row_ff;
      pend_in     = 1'b0;
      col_in      = col_ff;
      bits_in     = bits_ff;
      done_in     = done_ff;
      rd_en       = 1'b0;
      rd_addr     = {col_ff, row_ff[RW-1:0]};
      wr_en       = 1'b0;
      wr_addr     = {col_ff, dst_row[RW-1:0]};
      wr_data     = (rd_data_ff == 6'd0) ? 6'd0 : rd_data_ff - 6'(decay);

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_row_in   = rsp_row_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = (clr_addr_ff[RW-1:0] == RW'(GRID_SIZE - 1)) ? HEAT_MAX : 6'd0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_CLEAR) begin
                  state_in    = ST_CLEAR;
                  clr_addr_in = '0;
               end else if (col_ok) begin
                  state_in = ST_UPD;
                  col_in   = RW'(req_column);
                  bits_in  = req_decay_bits;
                  done_in  = frame_done;
                  row_in   = CW'(FIRST_SOURCE_ROW);
               end
            end
         end
         ST_UPD: begin
            // read the next source row while the previous one is written back
            if (issue) begin
               rd_en   = 1'b1;
               row_in  = row_ff + CW'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_EMIT_RD;
               row_in   = '0;
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = 4'(row_ff);
               rsp_rgb_in   = fhp_palette(rd_data_ff);
               rsp_last_in  = emit_last;
               rsp_done_in  = emit_last && done_ff;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
                  row_in   = row_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      limit_in = (csr_valid && csr_ready) ? csr_frame_limit : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      bits_ff     <= bits_in;
      done_ff     <= done_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_rgb_ff  <= rsp_rgb_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_red        = rsp_rgb_ff[23:16];
   assign rsp_green      = rsp_rgb_ff[15:8];
   assign rsp_blue       = rsp_rgb_ff[7:0];
   assign rsp_last       = rsp_last_ff;
   assign rsp_frame_done = rsp_done_ff;

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last)
      else $error("frame_done without last");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en |-> rd_addr != wr_addr)
      else $error("store read and write hit the same entry");

   a_write_above: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPD && pend_ff |-> dst_row < src_row)
      else $error("heat written at or below its source row");

   a_clear_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_op == OP_CLEAR |=> state_ff == ST_CLEAR && clr_addr_ff == '0)
      else $error("store reset item did not start a clearing pass");

endmodule

// ===== sv/fhp_frame_ctr.sv =====
// Frame counter that flags the last column of every limit-th frame.
module fhp_frame_ctr (
   input  logic                      clock,
   input  logic                      reset,
   input  fhp_pkg::fhp_frame_cmd_type cmd,
   input  logic [15:0]               frame_limit,
   output logic                      done
);
   import fhp_pkg::*;

   logic [15:0] count_ff;
   logic [15:0] count_in;
   logic        limit_ff;
   logic        limit_in;
   logic [15:0] count_inc;
   logic        limit_next;

   always_comb begin
      count_inc  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
      limit_next = limit_ff;
      count_in   = count_ff;
      if (cmd.start && cmd.first_col) begin
         count_in   = count_inc;
         limit_next = (count_inc >= frame_limit);
      end
      done     = cmd.start && cmd.last_col && limit_next;
      limit_in = limit_next;
      if (done) begin
         count_in = '0;
         limit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         limit_ff <= limit_in;
      end
   end

endmodule

// ===== tb/fire_pixel_checker.sv =====
// Checker for the fire heat propagation unit: predicts each column's pixels and compares them.
module fire_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_op,
   input  logic [3:0]  req_column,
   input  logic [15:0] req_decay_bits,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_row,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic        rsp_last,
   input  logic        rsp_frame_done,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_frame_limit,
   output int          fail_count,
   output int          pending_count
);
   import fhp_pkg::*;

   localparam logic [23:0] FIRE_RGB [0:36] = '{
      24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
      24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
      24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
      24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
      24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
      24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
      24'hFFFFFF
   };

   typedef struct packed {
      logic [3:0]  row;
      logic [23:0] rgb;
      logic        last;
      logic        frame_done;
   } fire_pixel_type;

   logic [5:0]     heat [0:FHP_GRID_SIZE-1][0:FHP_GRID_SIZE-1];
   logic [15:0]    frame_count;
   logic           limit_frame;
   logic [15:0]    frame_limit;
   fire_pixel_type pixel_queue [$];

   task automatic clear_heat();
      int c;
      int r;
      for (c = 0; c < FHP_GRID_SIZE; c++) begin
         for (r = 0; r < FHP_GRID_SIZE; r++) begin
            heat[c][r] = (r == FHP_GRID_SIZE - 1) ? HEAT_MAX : 6'd0;
         end
      end
   endtask

   task automatic advance_fire(input logic op, input logic [3:0] col,
                               input logic [15:0] bits);
      int r;
      int dst;
      logic [5:0] src;
      logic [5:0] h;
      logic b;
      logic done;
      fire_pixel_type px;
      if (op == OP_CLEAR) begin
         clear_heat();
      end else begin
         if (col == 4'd0) begin
            if (frame_count != COUNT_MAX) frame_count = frame_count + 16'd1;
            limit_frame = (frame_count >= frame_limit);
         end
         for (r = FHP_FIRST_SOURCE_ROW; r < FHP_GRID_SIZE; r++) begin
            src = heat[col][r];
            if (src == 6'd0) begin
               heat[col][r-1] = 6'd0;
            end else begin
               b = bits[r];
               dst = r - 1 - int'(b);
               heat[col][dst] = src - {5'd0, b};
            end
         end
         done = 1'b0;
         if (int'(col) == FHP_GRID_SIZE - 1 && limit_frame) begin
            done = 1'b1;
            frame_count = 16'd0;
            limit_frame = 1'b0;
         end
         for (r = 0; r < FHP_MAX_EMIT; r++) begin
            h = heat[col][r];
            if (h > HEAT_MAX) h = HEAT_MAX;
            px.row = r[3:0];
            px.rgb = FIRE_RGB[h];
            px.last = (r == FHP_MAX_EMIT - 1);
            px.frame_done = px.last && done;
            pixel_queue.push_back(px);
         end
      end
   endtask

   task automatic flag(input string field, input logic [23:0] expv, input logic [23:0] actv);
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, expv, actv);
   endtask

   task automatic check_pixel();
      fire_pixel_type px;
      if (pixel_queue.size() == 0) begin
         fail_count++;
         $display("%0t: pixel with none expected, row %0d rgb %h%h%h", $time, rsp_row,
                  rsp_red, rsp_green, rsp_blue);
      end else begin
         px = pixel_queue.pop_front();
         if (rsp_row !== px.row) flag("row", 24'(px.row), 24'(rsp_row));
         if (rsp_red !== px.rgb[23:16]) flag("red", 24'(px.rgb[23:16]), 24'(rsp_red));
         if (rsp_green !== px.rgb[15:8]) flag("green", 24'(px.rgb[15:8]), 24'(rsp_green));
         if (rsp_blue !== px.rgb[7:0]) flag("blue", 24'(px.rgb[7:0]), 24'(rsp_blue));
         if (rsp_last !== px.last) flag("last", 24'(px.last), 24'(rsp_last));
         if (rsp_frame_done !== px.frame_done) begin
            flag("frame_done", 24'(px.frame_done), 24'(rsp_frame_done));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_heat();
         frame_count = 16'd0;
         limit_frame = 1'b0;
         frame_limit = LIMIT_RESET;
         pixel_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_pixel();
         if (csr_valid && csr_ready) frame_limit = csr_frame_limit;
         if (req_valid && !req_stall) advance_fire(req_op, req_column, req_decay_bits);
      end
      pending_count = pixel_queue.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the fire heat propagation testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
   import fhp_pkg::*;

   localparam int SETTLE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 25;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_op;
   logic [3:0]  req_column;
   logic [15:0] req_decay_bits;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_row;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic        rsp_last;
   logic        rsp_frame_done;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_frame_limit;
   int          fail_count;
   int          pending_count;
   int          idle_pct;
   int          stall_pct;
   int          quiet_cycles;

   fire_heat_propagation_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_column(req_column), .req_decay_bits(req_decay_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_row(rsp_row),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_last(rsp_last), .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_frame_limit(csr_frame_limit)
   );

   fire_pixel_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_column(req_column), .req_decay_bits(req_decay_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_row(rsp_row),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .rsp_last(rsp_last), .rsp_frame_done(rsp_frame_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_frame_limit(csr_frame_limit),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [15:0] draw_decay();
      logic [15:0] bits;
      int i;
      for (i = 0; i < 16; i++) bits[i] = ($urandom_range(2) == 1);
      return bits;
   endfunction

   task automatic send_item(input logic op, input logic [3:0] col, input logic [15:0] bits);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_column     <= col;
      req_decay_bits <= bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_limit(input logic [15:0] value);
      drain_pixels();
      csr_valid       <= 1'b1;
      csr_frame_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int idle, input int stall, input logic [15:0] limit);
      int items;
      int pick;
      int n;
      logic [3:0] col;
      program_limit(limit);
      idle_pct  = idle;
      stall_pct = stall;
      items = 0;
      while (items < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_item(OP_UPDATE, 4'd0, draw_decay());
            n = $urandom_range(3);
            repeat (n) begin
               col = 4'($urandom_range(14, 1));
               send_item(OP_UPDATE, col, draw_decay());
            end
            send_item(OP_UPDATE, 4'd15, draw_decay());
            items += n + 2;
         end else if (pick < 93) begin
            col = 4'($urandom_range(15));
            send_item(OP_UPDATE, col, 16'($urandom_range(16'hFFFF)));
            items++;
         end else begin
            col = 4'($urandom_range(15));
            send_item(OP_CLEAR, col, 16'($urandom_range(16'hFFFF)));
            items++;
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_UPDATE;
      req_column      = 4'd0;
      req_decay_bits  = 16'd0;
      csr_valid       = 1'b0;
      csr_frame_limit = 16'd0;
      idle_pct        = 0;
      stall_pct       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(OP_UPDATE, 4'd0, 16'h0000);
      send_item(OP_UPDATE, 4'd0, 16'hFFFF);
      send_item(OP_UPDATE, 4'd15, 16'hFFFF);
      send_item(OP_UPDATE, 4'd15, 16'h0000);
      send_item(OP_UPDATE, 4'd15, 16'hAAAA);
      send_item(OP_UPDATE, 4'd15, 16'h5555);
      repeat (6) send_item(OP_UPDATE, 4'd3, 16'hFFFF);
      repeat (6) send_item(OP_UPDATE, 4'd9, 16'h0000);
      send_item(OP_CLEAR, 4'd15, 16'hFFFF);
      send_item(OP_UPDATE, 4'd3, 16'hFFFF);
      send_item(OP_CLEAR, 4'd0, 16'h0000);
      send_item(OP_UPDATE, 4'd9, 16'h0000);
      send_item(OP_UPDATE, 4'd15, 16'hFFFF);

      run_phase(0, 0, 16'd1);
      run_phase(82, 0, 16'd0);
      run_phase(0, 82, 16'hFFFF);
      run_phase(31, 31, 16'd3);

      idle_pct = 0;
      drain_pixels();
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
